// File: rtl/iits_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// iits_pkg
// shared widths, codes and payload types of the imu / image timestamp
// synchronizer
// ============================================================================
package iits_pkg;

    // field widths
    localparam int STAMP_W   = 48;
    localparam int HANDLE_W  = 16;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 3;
    localparam int ENTRY_W   = HANDLE_W + STAMP_W;

    // configuration register widths
    localparam int DELAY_W    = 21;
    localparam int GAP_W      = 24;
    localparam int ULIM_W     = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // signed width for stamp +/- delay + gap arithmetic
    localparam int CALC_W = STAMP_W + 2;

    // queue depths and derived index / count widths
    localparam int FRAME_DEPTH    = 16;
    localparam int INERTIAL_DEPTH = 32;
    localparam int FRAME_AW       = $clog2(FRAME_DEPTH);
    localparam int FRAME_CW       = $clog2(FRAME_DEPTH + 1);
    localparam int INERTIAL_AW    = $clog2(INERTIAL_DEPTH);
    localparam int INERTIAL_CW    = $clog2(INERTIAL_DEPTH + 1);

    // frames kept in real-time mode
    localparam int RT_FRAME_CAP = 2;

    // register reset values
    localparam logic [GAP_W-1:0]  GAP_LIMIT_RST    = GAP_W'(3000000);
    localparam logic [ULIM_W-1:0] UNSYNC_LIMIT_RST = ULIM_W'(10);
    localparam logic [ULIM_W-1:0] UNSYNC_MAX       = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSYNC_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_TIME    = 2'd3;

    // operation codes
    localparam logic [OP_W-1:0] OP_INERTIAL = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME    = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_READY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GAP_CLEAR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNSYNC    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FRAME     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_INERTIAL  = 3'd7;

    // start-up sync modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_INIT   = 2'd1;
    localparam logic [1:0] MODE_NORMAL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] out_handle;
        logic [STAMP_W-1:0]  out_stamp;
        logic                last;
    } t_out_item;

endpackage

// File: rtl/iits_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// iits_ram
// simple dual-port ram, one write and one registered read port
// ============================================================================
module iits_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/imu_image_timestamp_synchronizer.sv
`timescale 1ns / 1ps
// ============================================================================
// imu_image_timestamp_synchronizer
// pairs camera frames with inertial samples by timestamp; two ring queues in
// ram, a start-up filter for arrivals and a sequenced fetch that grants the
// oldest frame and the inertial samples due before it
// ============================================================================
//
// channel   direction  handshake            payload
// --------  ---------  -------------------  ------------------------------
// in        input      i_in_valid/o_in_stall   t_in_item  i_in_data
// out       output     o_out_valid/i_out_stall t_out_item o_out_data
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item is in work at a time; o_in_stall is low only in the idle state,
// and the idle state is reached while the last result may still sit in the
// output register
// an arrival or unused code is accepted in the idle state, then decoded and acted on
// in the decode state; a fetch then reads ram twice, for the gap and due checks, and
// walks the inertial entries in the walk state up to the first one not yet due
// any cycle that must hand a result over waits while the output register is
// full and stalled
// reset is synchronous, active low; it empties both queues and needs no
// clearing pass since queue entries are only read below the fill count
// ============================================================================
module imu_image_timestamp_synchronizer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  iits_pkg::t_in_item                     i_in_data,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output iits_pkg::t_out_item                    o_out_data,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [iits_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [iits_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import iits_pkg::*;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_GAP    = 5'b00100,
        ST_DUE    = 5'b01000,
        ST_WALK   = 5'b10000
    } t_state;

    // ring index wrap, sum is below twice the depth
    function automatic logic [FRAME_AW-1:0] frame_wrap(input logic [FRAME_AW:0] sum);
        logic [FRAME_AW:0] v;
        v = (sum >= (FRAME_AW+1)'(FRAME_DEPTH)) ? sum - (FRAME_AW+1)'(FRAME_DEPTH) : sum;
        return v[FRAME_AW-1:0];
    endfunction

    function automatic logic [INERTIAL_AW-1:0] inertial_wrap(
        input logic [INERTIAL_AW:0] sum
    );
        logic [INERTIAL_AW:0] v;
        v = (sum >= (INERTIAL_AW+1)'(INERTIAL_DEPTH)) ?
            sum - (INERTIAL_AW+1)'(INERTIAL_DEPTH) : sum;
        return v[INERTIAL_AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    // configuration
    logic signed [DELAY_W-1:0] r_image_delay;
    logic [GAP_W-1:0]          r_gap_limit;
    logic [ULIM_W-1:0]         r_unsync_limit;
    logic                      r_real_time;

    // control state
    t_state                    r_state,  n_state;
    logic [1:0]                r_mode,   n_mode;
    logic [STAMP_W-1:0]        r_start,  n_start;
    logic [FRAME_AW-1:0]       r_fhead,  n_fhead;
    logic [FRAME_CW-1:0]       r_fcount, n_fcount;
    logic [INERTIAL_AW-1:0]    r_ihead,  n_ihead;
    logic [INERTIAL_CW-1:0]    r_icount, n_icount;
    logic [ULIM_W-1:0]         r_unsync, n_unsync;
    logic                      r_out_valid;

    // payload
    t_in_item                  r_item,   n_item;
    logic signed [CALC_W-1:0]  r_due,    n_due;
    t_out_item                 r_pend,   n_pend;
    t_out_item                 r_out;

    // ------------------------------------------------------------------
    // ram ports
    // ------------------------------------------------------------------
    logic                      w_f_we, w_f_re;
    logic [FRAME_AW-1:0]       w_f_waddr, w_f_raddr;
    logic [ENTRY_W-1:0]        w_f_rdata;
    logic                      w_i_we, w_i_re;
    logic [INERTIAL_AW-1:0]    w_i_waddr, w_i_raddr;
    logic [ENTRY_W-1:0]        w_i_rdata;
    logic [ENTRY_W-1:0]        w_wdata;

    // queue entries are {handle, stamp}
    assign w_wdata = {r_item.handle, r_item.stamp};

    iits_ram #(
        .DEPTH (FRAME_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_f_we),
        .i_waddr (w_f_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_f_re),
        .i_raddr (w_f_raddr),
        .o_rdata (w_f_rdata)
    );

    iits_ram #(
        .DEPTH (INERTIAL_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_inertial_ram (
        .i_clk   (i_clk),
        .i_we    (w_i_we),
        .i_waddr (w_i_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_i_re),
        .i_raddr (w_i_raddr),
        .o_rdata (w_i_rdata)
    );

    // ------------------------------------------------------------------
    // timestamp arithmetic, all signed at CALC_W bits
    // ------------------------------------------------------------------
    logic signed [CALC_W-1:0] w_delay_x, w_gap_x, w_start_x, w_stamp_x;
    logic signed [CALC_W-1:0] w_f_rd_stamp, w_i_rd_stamp;
    logic signed [CALC_W-1:0] w_gap_sum, w_due;
    logic                     w_delay_neg;
    logic                     w_after_i, w_after_f;
    logic                     w_gap_fail, w_due_late, w_walk_due;

    assign w_delay_x    = CALC_W'(r_image_delay);
    assign w_gap_x      = CALC_W'(r_gap_limit);
    assign w_start_x    = CALC_W'(r_start);
    assign w_stamp_x    = CALC_W'(r_item.stamp);
    assign w_f_rd_stamp = CALC_W'(w_f_rdata[STAMP_W-1:0]);
    assign w_i_rd_stamp = CALC_W'(w_i_rdata[STAMP_W-1:0]);
    assign w_delay_neg  = r_image_delay[DELAY_W-1];

    // start-up filter comparisons against the first stamp seen
    assign w_after_i = (w_stamp_x + w_delay_x) > w_start_x;
    assign w_after_f = (w_stamp_x - w_delay_x) > w_start_x;

    // gap check: newest frame (shifted by delay and limit) behind oldest inertial
    assign w_gap_sum  = w_f_rd_stamp - w_delay_x + w_gap_x;
    assign w_gap_fail = w_gap_sum < w_i_rd_stamp;

    // due time of the oldest frame, must not pass the newest inertial sample
    assign w_due      = w_f_rd_stamp - w_delay_x;
    assign w_due_late = w_due > w_i_rd_stamp;

    // walked inertial sample is older than the frame due time
    assign w_walk_due = w_i_rd_stamp < r_due;

    // ------------------------------------------------------------------
    // arrival: filter, push with drop-oldest, real-time frame cap
    // ------------------------------------------------------------------
    logic                   a_accept, a_drop;
    logic                   a_i_push, a_f_push, a_i_full, a_f_full;
    logic [1:0]             a_mode;
    logic [STAMP_W-1:0]     a_start;
    logic [KIND_W-1:0]      a_kind;
    logic [INERTIAL_AW-1:0] a_i_waddr, a_ihead;
    logic [INERTIAL_CW-1:0] a_icount;
    logic [FRAME_AW-1:0]    a_f_waddr, a_fhead;
    logic [FRAME_CW-1:0]    a_fcount;

    assign a_i_full  = r_icount == INERTIAL_CW'(INERTIAL_DEPTH);
    assign a_f_full  = r_fcount == FRAME_CW'(FRAME_DEPTH);
    // tail slot; equals the head when full, which overwrites the oldest entry
    assign a_i_waddr = inertial_wrap({1'b0, r_ihead} + (INERTIAL_AW+1)'(r_icount));
    assign a_f_waddr = frame_wrap({1'b0, r_fhead} + (FRAME_AW+1)'(r_fcount));

    always_comb begin
        a_accept = 1'b0;
        a_mode   = r_mode;
        a_start  = r_start;
        if (r_item.operation == OP_INERTIAL) begin
            if (!w_delay_neg) begin
                a_accept = 1'b1;
                if (r_mode == MODE_NONE) begin
                    a_start = r_item.stamp;
                    a_mode  = MODE_INIT;
                end
            end else if (r_mode == MODE_INIT) begin
                if (w_after_i) begin
                    a_accept = 1'b1;
                    a_mode   = MODE_NORMAL;
                end
            end else if (r_mode != MODE_NONE) begin
                a_accept = 1'b1;
            end
        end else begin
            if (!w_delay_neg) begin
                if (r_mode == MODE_INIT) begin
                    if (w_after_f) begin
                        a_accept = 1'b1;
                        a_mode   = MODE_NORMAL;
                    end
                end else if (r_mode != MODE_NONE) begin
                    a_accept = 1'b1;
                end
            end else if (r_mode == MODE_NONE) begin
                // negative delay: the first frame only marks the start
                a_start = r_item.stamp;
                a_mode  = MODE_INIT;
            end else begin
                a_accept = 1'b1;
            end
        end

        a_i_push = a_accept && (r_item.operation == OP_INERTIAL);
        a_f_push = a_accept && (r_item.operation == OP_FRAME);
        a_drop   = 1'b0;

        a_ihead  = r_ihead;
        a_icount = r_icount;
        if (a_i_push) begin
            if (a_i_full) begin
                a_ihead = inertial_wrap({1'b0, r_ihead} + 1'b1);
                a_drop  = 1'b1;
            end else begin
                a_icount = r_icount + 1'b1;
            end
        end

        a_fhead  = r_fhead;
        a_fcount = r_fcount;
        if (a_f_push) begin
            if (a_f_full) begin
                a_fhead = frame_wrap({1'b0, r_fhead} + 1'b1);
                a_drop  = 1'b1;
            end else begin
                a_fcount = r_fcount + 1'b1;
            end
        end
        // real-time cap trims one frame per frame arrival while above the cap, accepted or not
        if ((r_item.operation == OP_FRAME) && r_real_time &&
            (a_fcount > FRAME_CW'(RT_FRAME_CAP))) begin
            a_fhead  = frame_wrap({1'b0, a_fhead} + 1'b1);
            a_fcount = a_fcount - 1'b1;
            a_drop   = 1'b1;
        end

        a_kind = a_accept ? (a_drop ? KIND_DROPPED : KIND_ACCEPTED) : KIND_IGNORED;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic      w_out_free;
    logic      w_emit;
    t_out_item w_emit_item;
    logic      w_fetch_wait;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_fetch_wait = (r_mode == MODE_NONE) || (r_mode == MODE_INIT) ||
                          (r_fcount == '0) || (r_icount == '0);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_start  = r_start;
        n_fhead  = r_fhead;
        n_fcount = r_fcount;
        n_ihead  = r_ihead;
        n_icount = r_icount;
        n_unsync = r_unsync;
        n_item   = r_item;
        n_due    = r_due;
        n_pend   = r_pend;

        w_emit      = 1'b0;
        w_emit_item = '0;

        w_f_we    = 1'b0;
        w_f_waddr = a_f_waddr;
        w_f_re    = 1'b0;
        w_f_raddr = r_fhead;
        w_i_we    = 1'b0;
        w_i_waddr = a_i_waddr;
        w_i_re    = 1'b0;
        w_i_raddr = r_ihead;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                case (r_item.operation)
                    OP_INERTIAL, OP_FRAME: begin
                        if (w_out_free) begin
                            w_f_we   = a_f_push;
                            w_i_we   = a_i_push;
                            n_mode   = a_mode;
                            n_start  = a_start;
                            n_fhead  = a_fhead;
                            n_fcount = a_fcount;
                            n_ihead  = a_ihead;
                            n_icount = a_icount;
                            w_emit           = 1'b1;
                            w_emit_item.kind = a_kind;
                            w_emit_item.last = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end
                    OP_FETCH: begin
                        if (w_fetch_wait) begin
                            if (w_out_free) begin
                                w_emit           = 1'b1;
                                w_emit_item.kind = KIND_NOT_READY;
                                w_emit_item.last = 1'b1;
                                n_state          = ST_IDLE;
                            end
                        end else begin
                            // newest frame and oldest inertial sample
                            w_f_re    = 1'b1;
                            w_f_raddr = frame_wrap({1'b0, r_fhead} +
                                                   (FRAME_AW+1)'(r_fcount - 1'b1));
                            w_i_re    = 1'b1;
                            w_i_raddr = r_ihead;
                            n_state   = ST_GAP;
                        end
                    end
                    default: begin
                        // unused operation code
                        if (w_out_free) begin
                            w_emit           = 1'b1;
                            w_emit_item.kind = KIND_IGNORED;
                            w_emit_item.last = 1'b1;
                            n_state          = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_GAP: begin
                if (w_gap_fail) begin
                    if (w_out_free) begin
                        n_fhead  = '0;
                        n_fcount = '0;
                        n_ihead  = '0;
                        n_icount = '0;
                        w_emit           = 1'b1;
                        w_emit_item.kind = KIND_GAP_CLEAR;
                        w_emit_item.last = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    // oldest frame and newest inertial sample
                    w_f_re    = 1'b1;
                    w_f_raddr = r_fhead;
                    w_i_re    = 1'b1;
                    w_i_raddr = inertial_wrap({1'b0, r_ihead} +
                                              (INERTIAL_AW+1)'(r_icount - 1'b1));
                    n_state   = ST_DUE;
                end
            end

            ST_DUE: begin
                if (w_due_late) begin
                    if (w_out_free) begin
                        w_emit           = 1'b1;
                        w_emit_item.kind = KIND_NOT_READY;
                        w_emit_item.last = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    // frame result is held back until we know whether it is last
                    n_due             = w_due;
                    n_pend.kind       = KIND_FRAME;
                    n_pend.out_handle = w_f_rdata[ENTRY_W-1:STAMP_W];
                    n_pend.out_stamp  = w_f_rdata[STAMP_W-1:0];
                    n_pend.last       = 1'b0;
                    n_fhead  = frame_wrap({1'b0, r_fhead} + 1'b1);
                    n_fcount = r_fcount - 1'b1;
                    w_i_re    = 1'b1;
                    w_i_raddr = r_ihead;
                    n_state   = ST_WALK;
                end
            end

            ST_WALK: begin
                // the newest sample is never due, so the walk always ends here
                if (w_walk_due) begin
                    if (w_out_free) begin
                        w_emit            = 1'b1;
                        w_emit_item       = r_pend;
                        n_pend.kind       = KIND_INERTIAL;
                        n_pend.out_handle = w_i_rdata[ENTRY_W-1:STAMP_W];
                        n_pend.out_stamp  = w_i_rdata[STAMP_W-1:0];
                        n_pend.last       = 1'b0;
                        n_ihead  = inertial_wrap({1'b0, r_ihead} + 1'b1);
                        n_icount = r_icount - 1'b1;
                        n_unsync = '0;
                        w_i_re    = 1'b1;
                        w_i_raddr = inertial_wrap({1'b0, r_ihead} + 1'b1);
                    end
                end else if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_unsync > r_unsync_limit) begin
                        // sync failure replaces the frame result
                        n_fhead  = '0;
                        n_fcount = '0;
                        n_ihead  = '0;
                        n_icount = '0;
                        n_unsync = '0;
                        w_emit_item.kind = KIND_UNSYNC;
                        w_emit_item.last = 1'b1;
                    end else begin
                        n_unsync = (r_unsync == UNSYNC_MAX) ? r_unsync : r_unsync + 1'b1;
                        w_emit_item      = r_pend;
                        w_emit_item.last = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_NONE;
            r_start     <= '0;
            r_fhead     <= '0;
            r_fcount    <= '0;
            r_ihead     <= '0;
            r_icount    <= '0;
            r_unsync    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_start  <= n_start;
            r_fhead  <= n_fhead;
            r_fcount <= n_fcount;
            r_ihead  <= n_ihead;
            r_icount <= n_icount;
            r_unsync <= n_unsync;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_due  <= n_due;
        r_pend <= n_pend;
        if (w_emit) begin
            r_out <= w_emit_item;
        end
    end

    // configuration transaction, taken whenever offered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_delay  <= '0;
            r_gap_limit    <= GAP_LIMIT_RST;
            r_unsync_limit <= UNSYNC_LIMIT_RST;
            r_real_time    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_DELAY:  r_image_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_GAP_LIMIT:    r_gap_limit    <= i_cfg_data[GAP_W-1:0];
                CFG_UNSYNC_LIMIT: r_unsync_limit <= i_cfg_data[ULIM_W-1:0];
                CFG_REAL_TIME:    r_real_time    <= i_cfg_data[0];
                default:          r_real_time    <= r_real_time;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
